// ===== rtl/core/vag_adpcm_decoder_top_defines.svh =====
// assertion macros shared by the vag adpcm decoder checker
`ifndef VAG_ADPCM_DECODER_TOP_DEFINES_SVH
`define VAG_ADPCM_DECODER_TOP_DEFINES_SVH

// same-cycle implication, masked while in reset
`define VAG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vag decoder assertion failed");

// next-cycle implication, masked while in reset
`define VAG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vag decoder assertion failed");

// next-cycle implication that also holds across reset
`define VAG_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vag decoder assertion failed");

`endif

// ===== rtl/core/vag_pkg.sv =====
// shared types, constants and coefficient tables for the vag adpcm decoder
package vag_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int HIST_W  = 40;
  localparam int COEF_W  = 8;
  localparam int PROD_W  = HIST_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int SAMP_W  = 16;
  localparam int SKIP_W  = 12;
  localparam int POS_W   = 4;
  localparam int PRED_W  = 3;
  localparam int SHIFT_W = 4;
  localparam int PRED_SCALE_SH = 6;

  localparam logic [SKIP_W-1:0] HEADER_SKIP_RESET = 12'd64;
  localparam logic [7:0]        END_FLAGS         = 8'h07;
  localparam logic [3:0]        PRED_MAX          = 4'd4;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [PRED_W-1:0]    pred;
    logic [SHIFT_W-1:0]   shift;
    logic [7:0]           data;
  } vag_cmd_t;

  // weight on history_one, in units of 1/64
  function automatic logic signed [COEF_W-1:0] coef_a(input logic [PRED_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // weight on history_two, in units of 1/64
  function automatic logic signed [COEF_W-1:0] coef_b(input logic [PRED_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/vag_adpcm_decoder_top.sv =====
// top level of the vag adpcm stream decoder
// Decodes a VAG (SPU ADPCM) byte stream into 16-bit PCM. A byte flagged by
// s_tuser starts a stream: the next header_skip bytes (that one included) are
// dropped, then 16-byte blocks follow (predictor/shift byte, flags byte,
// 14 data bytes). Each data byte yields two samples, low nibble first, the
// second one with m_tlast set. A flags byte of 7 yields one zero sample with
// m_tlast and m_tuser set and mutes the stream until the next flagged byte.
// Rate: a data byte occupies the sample datapath one nibble per cycle while the
// output is not stalled, because each sample's prediction needs the history
// written by the sample before it; header, skipped and ordinary flags bytes
// stay at the parser. Bytes are taken every cycle while the command queue has
// room, so the parser runs ahead of the datapath. A data byte passes through
// the command queue, stage a and the output register to its first sample.
// The filter history survives stream restarts and is cleared only by rst.
// header_skip resets to 64 and may be written through cfg while idle; it
// takes effect at the next flagged byte.
module vag_adpcm_decoder_top
  import vag_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,   // fraction bits of the history, 6 to 24
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // command queue entries, at least 2
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write: header_skip
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SKIP_W-1:0] cfg_data,     // [11:0] header_skip
  // encoded byte stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,      // [7:0] data_byte
  input  logic              s_tuser,      // [0] first_byte
  // decoded samples
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [SAMP_W-1:0] m_tdata,      // [15:0] sample
  output logic              m_tlast,      // last sample of a byte or end marker
  output logic              m_tuser       // [0] end_of_stream
);

  logic     q_full, q_push, q_pop, q_valid, in_fire;
  vag_cmd_t q_wr, q_rd;

  // config is always accepted; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  // the queue decouples the parser from the datapath stall
  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  vag_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .in_byte  (s_tdata),
    .in_first (s_tuser),
    .push     (q_push),
    .cmd      (q_wr)
  );

  vag_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_cmd  (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_valid(q_valid),
    .rd_cmd  (q_rd)
  );

  // one sample per transfer out of the output register
  vag_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_rd),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

// ===== rtl/core/vag_front.sv =====
// byte parser: header skip, block position tracking and command generation
module vag_front
  import vag_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [SKIP_W-1:0] cfg_data,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              in_first,
  output logic              push,
  output vag_cmd_t          cmd
);

  localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
  localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;
  localparam logic [POS_W-1:0] POS_DATA0  = 4'd2;

  logic [SKIP_W-1:0]  header_skip;
  logic [SKIP_W-1:0]  skip_count, skip_count_next;
  logic [POS_W-1:0]   block_pos, block_pos_next;
  logic [PRED_W-1:0]  pred_idx, pred_idx_next;
  logic [SHIFT_W-1:0] shift_amt, shift_amt_next;
  logic               ended, ended_next;

  logic [SKIP_W-1:0]  eff_skip;
  logic [POS_W-1:0]   eff_pos;
  logic               eff_ended;

  always_comb begin
    eff_skip  = in_first ? header_skip : skip_count;
    eff_pos   = in_first ? POS_HEADER : block_pos;
    eff_ended = in_first ? 1'b0 : ended;

    skip_count_next = eff_skip;
    block_pos_next  = eff_pos;
    pred_idx_next   = pred_idx;
    shift_amt_next  = shift_amt;
    ended_next      = eff_ended;
    push            = 1'b0;
    cmd.kind        = CMD_DATA;
    cmd.pred        = pred_idx;
    cmd.shift       = shift_amt;
    cmd.data        = in_byte;

    if (!eff_ended) begin
      if (eff_skip != '0) begin
        skip_count_next = eff_skip - 1'b1;
      end else begin
        case (eff_pos)
          POS_HEADER: begin
            pred_idx_next  = (in_byte[7:4] <= PRED_MAX) ? in_byte[6:4] : '0;
            shift_amt_next = in_byte[3:0];
            block_pos_next = POS_FLAGS;
          end
          POS_FLAGS: begin
            if (in_byte == END_FLAGS) begin
              ended_next     = 1'b1;
              block_pos_next = POS_HEADER;
              push           = in_fire;
              cmd.kind       = CMD_END;
            end else begin
              block_pos_next = POS_DATA0;
            end
          end
          default: begin
            push           = in_fire;
            block_pos_next = eff_pos + 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_skip <= HEADER_SKIP_RESET;
      skip_count  <= '0;
      block_pos   <= POS_HEADER;
      pred_idx    <= '0;
      shift_amt   <= '0;
      ended       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        header_skip <= cfg_data;
      end
      if (in_fire) begin
        skip_count <= skip_count_next;
        block_pos  <= block_pos_next;
        pred_idx   <= pred_idx_next;
        shift_amt  <= shift_amt_next;
        ended      <= ended_next;
      end
    end
  end

endmodule

// ===== rtl/core/vag_fifo.sv =====
// small command queue between the parser and the sample datapath
module vag_fifo
  import vag_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  vag_cmd_t wr_cmd,
  output logic     full,
  input  logic     pop,
  output logic     rd_valid,
  output vag_cmd_t rd_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  vag_cmd_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/vag_back.sv =====
// sample datapath: predictor, history, rounding and output register
module vag_back
  import vag_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  vag_cmd_t          q_cmd,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [SAMP_W-1:0] m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  localparam int RND_W = HIST_W + 1;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (FRAC_BITS - 1);

  logic signed [HIST_W-1:0] hist_one, hist_two;
  logic                     nib_hi;

  // stage a: new history value waiting for rounding
  logic                     a_valid;
  logic signed [HIST_W-1:0] a_val;
  logic                     a_last;
  logic                     a_eos;

  logic b_adv, a_adv, fire, is_end;

  logic [3:0]               nib;
  logic signed [SAMP_W-1:0] scaled, raw16;
  logic signed [COEF_W-1:0] ca, cb;
  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic signed [SUM_W-1:0]  pred_sum, pred_sh, raw_ext, total;
  logic signed [HIST_W-1:0] sat_val;
  logic                     fits;

  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  rnd_q;
  logic                     rnd_adj;
  logic [SAMP_W-1:0]        rnd_samp;

  assign b_adv  = !m_tvalid || m_tready;
  assign a_adv  = !a_valid || b_adv;
  assign fire   = q_valid && a_adv;
  assign is_end = (q_cmd.kind == CMD_END);
  assign q_pop  = fire && (is_end || nib_hi);

  always_comb begin
    nib      = nib_hi ? q_cmd.data[7:4] : q_cmd.data[3:0];
    scaled   = {nib, 12'h000};
    raw16    = scaled >>> q_cmd.shift;
    ca       = coef_a(q_cmd.pred);
    cb       = coef_b(q_cmd.pred);
    prod_a   = PROD_W'(hist_one) * PROD_W'(ca);
    prod_b   = PROD_W'(hist_two) * PROD_W'(cb);
    pred_sum = SUM_W'(prod_a) + SUM_W'(prod_b);
    pred_sh  = pred_sum >>> PRED_SCALE_SH;
    raw_ext  = SUM_W'(raw16) <<< FRAC_BITS;
    total    = raw_ext + pred_sh;
    fits     = (total[SUM_W-1:HIST_W-1] == '0) || (total[SUM_W-1:HIST_W-1] == '1);
    if (fits) begin
      sat_val = total[HIST_W-1:0];
    end else if (total[SUM_W-1]) begin
      sat_val = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  // add one half, then truncate toward zero
  always_comb begin
    rnd      = RND_W'(a_val) + HALF;
    rnd_q    = rnd >>> FRAC_BITS;
    rnd_adj  = rnd[RND_W-1] && (rnd[FRAC_BITS-1:0] != '0);
    rnd_samp = rnd_q[SAMP_W-1:0] + SAMP_W'(rnd_adj);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_one <= '0;
      hist_two <= '0;
      nib_hi   <= 1'b0;
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (b_adv) begin
        m_tvalid <= a_valid;
      end
      if (fire) begin
        a_valid <= 1'b1;
        if (!is_end) begin
          hist_two <= hist_one;
          hist_one <= sat_val;
          nib_hi   <= !nib_hi;
        end
      end else if (b_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      a_val  <= is_end ? '0 : sat_val;
      a_last <= is_end || nib_hi;
      a_eos  <= is_end;
    end
    if (b_adv && a_valid) begin
      m_tdata <= rnd_samp;
      m_tlast <= a_last;
      m_tuser <= a_eos;
    end
  end

endmodule

// ===== rtl/core/vag_checker.sv =====
// port-level checker for the vag adpcm decoder, bound to the top level
`include "vag_adpcm_decoder_top_defines.svh"

module vag_checker
  import vag_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [SAMP_W-1:0] m_tdata,
  input logic              m_tlast,
  input logic              m_tuser
);

  `VAG_ASSERT_NOW(eos_is_last, m_tvalid && m_tuser, m_tlast)
  `VAG_ASSERT_NOW(eos_sample_zero, m_tvalid && m_tuser, m_tdata == '0)
  `VAG_ASSERT_NEXT(out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `VAG_ASSERT_RST(out_idle_after_rst, rst, !m_tvalid)

endmodule

bind vag_adpcm_decoder_top vag_checker u_vag_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for the vag adpcm decoder: encoded byte stream in, pcm samples checked out
module tb_top;
  import vag_pkg::*;

  localparam int     FRAC              = FRAC_BITS_DEF;
  localparam int     RESET_CYCLES      = 9;
  localparam int     DRAIN_CYCLES      = 32;     // parser queue plus sample datapath, with margin
  localparam int     CYCLE_LIMIT       = 400000;
  localparam int     ITEMS_PER_PHASE   = 280;
  localparam int     LONG_HEADER_BYTES = 120;    // part of the longest header, then abandoned
  localparam int     BLOCK_BYTES       = 16;
  localparam int     DATA_BYTES        = 14;
  localparam int     POS_HEADER        = 0;
  localparam int     POS_FLAGS         = 1;
  localparam longint HIST_MAX          = (64'sd1 <<< (HIST_W - 1)) - 1;
  localparam longint HIST_MIN          = -HIST_MAX - 1;
  localparam longint ROUND_HALF        = 64'sd1 <<< (FRAC - 1);

  // data bytes of the opening block: nibble extremes in both halves
  localparam logic [DATA_BYTES*8-1:0] EDGE_BYTES =
    112'h8778_F00F_1001_F77F_8877_0880_FF00;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } stream_byte_t;

  typedef struct packed {
    logic [SAMP_W-1:0] sample;
    logic              last;
    logic              eos;
  } pcm_result_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SKIP_W-1:0] cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [SAMP_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  stream_byte_t byte_queue[$];     // bytes waiting for the driver
  pcm_result_t  pcm_expected[$];   // predicted samples, oldest first
  stream_byte_t next_byte;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int counted        = 0;          // bytes queued for the driver
  int failures       = 0;
  int cycle_count    = 0;

  // decoder state as the bench tracks it
  logic [SKIP_W-1:0] skip_setting = HEADER_SKIP_RESET;
  int unsigned       skip_left    = 0;
  int unsigned       blk_pos      = POS_HEADER;
  int unsigned       pred_sel     = 0;
  int unsigned       shift_sel    = 0;
  longint            hist_last    = 0;
  longint            hist_prev    = 0;
  bit                muted        = 1'b0;

  always #10 clk = ~clk;

  vag_adpcm_decoder_top #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // one nibble through the two-tap filter; updates the history, returns the rounded sample
  function automatic logic [SAMP_W-1:0] decode_nibble(input logic [3:0] nib);
    longint code, scaled, weighted, acc, c_last, c_prev;
    code = nib;
    if (nib[3]) code = code - 16;
    case (pred_sel)
      1:       begin c_last = 60;  c_prev = 0;   end
      2:       begin c_last = 115; c_prev = -52; end
      3:       begin c_last = 98;  c_prev = -55; end
      4:       begin c_last = 122; c_prev = -60; end
      default: begin c_last = 0;   c_prev = 0;   end
    endcase
    scaled   = (code * 4096) >>> shift_sel;
    weighted = hist_last * c_last + hist_prev * c_prev;
    acc      = (scaled <<< FRAC) + (weighted >>> PRED_SCALE_SH);
    if (acc > HIST_MAX) acc = HIST_MAX;
    if (acc < HIST_MIN) acc = HIST_MIN;
    hist_prev = hist_last;
    hist_last = acc;
    // add one half, then truncate toward zero
    acc = acc + ROUND_HALF;
    if (acc < 0) acc = -((-acc) >>> FRAC);
    else acc = acc >>> FRAC;
    return acc[SAMP_W-1:0];
  endfunction

  // parse one accepted byte and queue the samples it yields
  function automatic void adpcm_step(input logic [7:0] b, input logic first);
    pcm_result_t r;
    if (first) begin
      skip_left = skip_setting;
      blk_pos   = POS_HEADER;
      muted     = 1'b0;
    end
    if (muted) return;
    if (skip_left > 0) begin
      skip_left--;
      return;
    end
    if (blk_pos == POS_HEADER) begin
      // predictor indexes above the table fall back to no prediction
      pred_sel  = (b[7:4] <= PRED_MAX) ? b[7:4] : 0;
      shift_sel = b[3:0];
      blk_pos   = POS_FLAGS;
    end else if (blk_pos == POS_FLAGS) begin
      if (b == END_FLAGS) begin
        muted    = 1'b1;
        blk_pos  = POS_HEADER;
        r.sample = '0;
        r.last   = 1'b1;
        r.eos    = 1'b1;
        pcm_expected.push_back(r);
      end else begin
        blk_pos = POS_FLAGS + 1;
      end
    end else begin
      r.eos    = 1'b0;
      r.sample = decode_nibble(b[3:0]);
      r.last   = 1'b0;
      pcm_expected.push_back(r);
      r.sample = decode_nibble(b[7:4]);
      r.last   = 1'b1;
      pcm_expected.push_back(r);
      blk_pos = (blk_pos + 1) % BLOCK_BYTES;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] d, input logic first);
    stream_byte_t sb;
    sb.data  = d;
    sb.first = first;
    byte_queue.push_back(sb);
    counted++;
  endfunction

  // one block; an end block is its header, the end flags and a few dead bytes
  function automatic void push_block(input bit end_it, input bit first);
    logic [3:0] pred;
    logic [3:0] shift;
    logic [7:0] flags;
    if ($urandom_range(0, 9) < 8) pred = 4'($urandom_range(0, 4));
    else pred = 4'($urandom_range(5, 15));
    shift = 4'($urandom);
    push_byte({pred, shift}, first);
    if (end_it) begin
      push_byte(END_FLAGS, 1'b0);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        flags = 8'($urandom);
        if (flags == END_FLAGS) flags = 8'h00;
      end else begin
        flags = $urandom_range(0, 1) ? 8'h02 : 8'h00;
      end
      push_byte(flags, 1'b0);
      repeat (DATA_BYTES) push_byte(8'($urandom), 1'b0);
    end
  endfunction

  // a flagged start, the header to skip, then blocks
  function automatic void push_stream(input int nblk, input bit end_it);
    if (skip_setting != 0) begin
      push_byte(8'($urandom), 1'b1);
      repeat (skip_setting - 1) push_byte(8'($urandom), 1'b0);
    end
    for (int i = 0; i < nblk; i++)
      push_block(end_it && i == nblk - 1, skip_setting == 0 && i == 0);
  endfunction

  // mostly well-formed streams, some bare blocks and some raw noise
  function automatic void fill_random(input int target);
    int goal;
    int pick;
    goal = counted + target;
    while (counted < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        push_stream($urandom_range(1, 4), $urandom_range(0, 9) < 7);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) push_block(1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          push_byte(8'($urandom), $urandom_range(0, 9) == 0);
        end
      end
    end
  endfunction

  // wait until every byte is in and every sample is out, then let the pipe drain
  task automatic settle();
    while (byte_queue.size() != 0 || s_tvalid || pcm_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_header_skip(input logic [SKIP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    skip_setting = v;
  endtask

  function automatic void check_sample();
    pcm_result_t want;
    if (pcm_expected.size() == 0) begin
      $display("%0t: unexpected sample, expected none, got %h last %b eos %b",
               $time, m_tdata, m_tlast, m_tuser);
      failures++;
      return;
    end
    want = pcm_expected.pop_front();
    if (m_tdata !== want.sample) begin
      $display("%0t: sample mismatch, expected %h, got %h", $time, want.sample, m_tdata);
      failures++;
    end
    if (m_tlast !== want.last) begin
      $display("%0t: last mismatch, expected %b, got %b", $time, want.last, m_tlast);
      failures++;
    end
    if (m_tuser !== want.eos) begin
      $display("%0t: end_of_stream mismatch, expected %b, got %b", $time, want.eos, m_tuser);
      failures++;
    end
  endfunction

  // byte driver: prediction happens on each accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) adpcm_step(s_tdata, s_tuser);
      if (!s_tvalid || s_tready) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_byte = byte_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_byte.data;
          s_tuser  <= next_byte.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sample monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_sample();
      m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // no flagged byte after reset, so blocks are parsed at once
    push_byte(8'hF7, 1'b0);          // predictor 15 stored as 0, shift 7
    push_byte(8'h00, 1'b0);          // ordinary flags
    for (int i = 0; i < DATA_BYTES; i++) push_byte(EDGE_BYTES[i*8 +: 8], 1'b0);
    push_byte(8'h40, 1'b0);          // strongest predictor, no shift
    push_byte(END_FLAGS, 1'b0);      // end marker
    push_byte(8'h5A, 1'b0);          // dropped after the end
    push_byte(8'hC3, 1'b0);
    settle();

    // reset header skip, no idling
    fill_random(ITEMS_PER_PHASE);
    settle();

    // no header, sender idling
    write_header_skip('0);
    send_idle_pct = 60;
    fill_random(ITEMS_PER_PHASE);
    settle();

    // longest header loaded and partly skipped, receiver stalling
    write_header_skip('1);
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    push_byte(8'($urandom), 1'b1);
    repeat (LONG_HEADER_BYTES) push_byte(8'($urandom), 1'b0);
    settle();

    write_header_skip(SKIP_W'($urandom_range(1, 8)));
    fill_random(ITEMS_PER_PHASE);
    settle();

    // both sides idling
    write_header_skip(SKIP_W'($urandom_range(2, 40)));
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    fill_random(ITEMS_PER_PHASE);
    settle();

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/vag_pkg.sv
rtl/core/vag_front.sv
rtl/core/vag_fifo.sv
rtl/core/vag_back.sv
rtl/core/vag_adpcm_decoder_top.sv
rtl/core/vag_checker.sv
bench/tb_top.sv
